/* src/masked_block_squared_error_core_macros.svh */
// ----------------------------------------------------------------------------
// masked_block_squared_error_core assertion macros
// Clocked assertion shorthands shared by the core's modules.
// ----------------------------------------------------------------------------
`ifndef MASKED_BLOCK_SQUARED_ERROR_CORE_MACROS_SVH
`define MASKED_BLOCK_SQUARED_ERROR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define MBSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset
`define MBSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/mbse_pkg.sv */
// ----------------------------------------------------------------------------
// mbse_pkg
// Widths and the block record passed from the front end to the back end.
// ----------------------------------------------------------------------------
package mbse_pkg;

	localparam int DENS_W  = 24;   // Q12.12 density
	localparam int SUM_W   = 32;   // block sum, saturating
	localparam int CPB_W   = 9;    // cells_per_block register
	localparam int TGT_W   = CPB_W + DENS_W;
	localparam int ERR_W   = 64;   // squared error and total, Q40.24
	localparam int QDEPTH  = 4;    // block record queue depth
	localparam int QIDX_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = QIDX_W + 1;

	// One finished block, ready for the error computation
	typedef struct packed {
		logic              clr_total;  // clear the total before this block
		logic [DENS_W-1:0] obs;        // observed density
		logic [SUM_W-1:0]  sum;        // masked prediction sum
		logic              any_open;   // at least one open cell
		logic              grid_last;  // last block of the pass
	} blk_rec_t;

endpackage

/* src/mbse_front.sv */
// ----------------------------------------------------------------------------
// mbse_front
// Accepts cells, accumulates the masked block sum and emits one block record.
// ----------------------------------------------------------------------------
module mbse_front (
	input  logic                            clk,
	input  logic                            arst_n,
	// cell request
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [mbse_pkg::DENS_W-1:0]     pred,
	input  logic                            cell_open,
	input  logic [mbse_pkg::DENS_W-1:0]     obs,
	input  logic                            block_last,
	input  logic                            grid_last,
	input  logic                            start_run,
	// record queue write side
	output logic                            rec_push,
	output mbse_pkg::blk_rec_t              rec,
	input  logic                            rec_full
);
	import mbse_pkg::*;

	logic [SUM_W-1:0]  sum_q;
	logic              any_open_q;
	logic              clr_pend_q;
	logic              accept;
	logic              blk_end;
	logic [SUM_W-1:0]  sum_base;
	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_next;
	logic              open_next;

	assign in_ready = !rec_full;
	assign accept   = in_valid && in_ready;
	assign blk_end  = block_last || grid_last;

	// Saturating masked sum; start of run drops any partial block
	always_comb begin
		sum_base  = start_run ? '0 : sum_q;
		sum_ext   = {1'b0, sum_base} + {{(SUM_W + 1 - DENS_W){1'b0}}, pred};
		sum_next  = sum_base;
		open_next = any_open_q && !start_run;
		if (cell_open) begin
			sum_next  = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
			open_next = 1'b1;
		end
	end

	// Record for the back end
	assign rec_push      = accept && blk_end;
	assign rec.clr_total = clr_pend_q || start_run;
	assign rec.obs       = obs;
	assign rec.sum       = sum_next;
	assign rec.any_open  = open_next;
	assign rec.grid_last = grid_last;

	// Block accumulator; a total clear is held until the next block record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			any_open_q <= 1'b0;
			clr_pend_q <= 1'b0;
		end else if (accept) begin
			if (blk_end) begin
				sum_q      <= '0;
				any_open_q <= 1'b0;
				clr_pend_q <= 1'b0;
			end else begin
				sum_q      <= sum_next;
				any_open_q <= open_next;
				clr_pend_q <= clr_pend_q || start_run;
			end
		end
	end

endmodule

/* src/mbse_fifo.sv */
// ----------------------------------------------------------------------------
// mbse_fifo
// Short queue of block records between the front and back ends.
// ----------------------------------------------------------------------------
`include "masked_block_squared_error_core_macros.svh"

module mbse_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mbse_pkg::blk_rec_t   wr_data,
	output logic                 full,
	input  logic                 pop,
	output mbse_pkg::blk_rec_t   rd_data,
	output logic                 not_empty
);
	import mbse_pkg::*;

	blk_rec_t            mem_q [QDEPTH];
	logic [QIDX_W-1:0]   wr_ptr_q;
	logic [QIDX_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign not_empty = (count_q != '0);
	assign do_wr     = push && !full;
	assign do_rd     = pop && not_empty;
	assign rd_data   = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`MBSE_ASSERT_NOW(a_cnt_bound, 1'b1, count_q <= QCNT_W'(QDEPTH), "queue count over depth")
	`MBSE_ASSERT_NEXT(a_cnt_up, do_wr && !do_rd, count_q == $past(count_q) + 1'b1, "count missed push")
	`MBSE_ASSERT_NEXT(a_cnt_dn, do_rd && !do_wr, count_q == $past(count_q) - 1'b1, "count missed pop")

endmodule

/* src/mbse_back.sv */
// ----------------------------------------------------------------------------
// mbse_back
// Per-block squared error and saturating total, four-stage pipeline.
// ----------------------------------------------------------------------------
`include "masked_block_squared_error_core_macros.svh"

module mbse_back #(
	parameter int MAX_BLOCK_CELLS = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [mbse_pkg::CPB_W-1:0]    cfg_wdata,
	// record queue read side
	input  logic                          rec_valid,
	input  mbse_pkg::blk_rec_t            rec,
	output logic                          rec_pop,
	// result request
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mbse_pkg::ERR_W-1:0]    block_error,
	output logic [mbse_pkg::ERR_W-1:0]    running_total,
	output logic                          block_counted,
	output logic                          run_done
);
	import mbse_pkg::*;

	localparam int CPB_MAXV = (1 << CPB_W) - 1;
	localparam int CPB_CAP  = (MAX_BLOCK_CELLS > CPB_MAXV) ? CPB_MAXV : MAX_BLOCK_CELLS;
	localparam int D_W      = ERR_W / 2;

	logic [CPB_W-1:0]  cpb_q;
	logic [CPB_W-1:0]  cpb_eff;
	logic              en;

	// stage 1: target product
	logic              v_s1;
	logic [TGT_W-1:0]  tgt_s1;
	logic [SUM_W-1:0]  sum_s1;
	logic              ok_s1;
	logic              gl_s1;
	logic              clr_s1;
	// stage 2: absolute difference
	logic              v_s2;
	logic [D_W-1:0]    d_s2;
	logic              big_s2;
	logic              ok_s2;
	logic              gl_s2;
	logic              clr_s2;
	// stage 3: square
	logic              v_s3;
	logic [ERR_W-1:0]  err_s3;
	logic              ok_s3;
	logic              gl_s3;
	logic              clr_s3;
	// output
	logic              out_v_q;
	logic [ERR_W-1:0]  err_q;
	logic [ERR_W-1:0]  total_q;
	logic              counted_q;
	logic              done_q;

	logic [TGT_W-1:0]  diff;
	logic [ERR_W-1:0]  tot_base;
	logic [ERR_W:0]    tot_ext;

	assign en      = !out_v_q || out_ready;
	assign rec_pop = en && rec_valid;
	assign cpb_eff = (cpb_q > CPB_W'(CPB_CAP)) ? CPB_W'(CPB_CAP) : cpb_q;

	// Block size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpb_q <= CPB_W'(1);
		end else if (cfg_we) begin
			cpb_q <= cfg_wdata;
		end
	end

	// |target - sum| over the stage 1 values
	always_comb begin
		if (tgt_s1 > TGT_W'(sum_s1)) begin
			diff = tgt_s1 - TGT_W'(sum_s1);
		end else begin
			diff = TGT_W'(sum_s1) - tgt_s1;
		end
	end

	// Saturating total update
	assign tot_base = clr_s3 ? '0 : total_q;
	assign tot_ext  = {1'b0, tot_base} + {1'b0, err_s3};

	// Stage valids, total and result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			total_q <= '0;
		end else if (en) begin
			v_s1    <= rec_valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			out_v_q <= v_s3;
			if (v_s3) begin
				total_q <= tot_ext[ERR_W] ? {ERR_W{1'b1}} : tot_ext[ERR_W-1:0];
			end
		end
	end

	// Payload pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			tgt_s1 <= TGT_W'(cpb_eff) * TGT_W'(rec.obs);
			sum_s1 <= rec.sum;
			ok_s1  <= (rec.obs != '0) && rec.any_open && (rec.sum != '0);
			gl_s1  <= rec.grid_last;
			clr_s1 <= rec.clr_total;

			d_s2   <= diff[D_W-1:0];
			big_s2 <= (diff[TGT_W-1:D_W] != '0);
			ok_s2  <= ok_s1;
			gl_s2  <= gl_s1;
			clr_s2 <= clr_s1;

			if (!ok_s2) begin
				err_s3 <= '0;
			end else if (big_s2) begin
				err_s3 <= {ERR_W{1'b1}};
			end else begin
				err_s3 <= {{D_W{1'b0}}, d_s2} * {{D_W{1'b0}}, d_s2};
			end
			ok_s3  <= ok_s2;
			gl_s3  <= gl_s2;
			clr_s3 <= clr_s2;

			err_q     <= err_s3;
			counted_q <= ok_s3;
			done_q    <= gl_s3;
		end
	end

	assign out_valid     = out_v_q;
	assign block_error   = err_q;
	assign running_total = total_q;
	assign block_counted = counted_q;
	assign run_done      = done_q;

	`MBSE_ASSERT_NEXT(a_stall_hold, out_v_q && !out_ready, $stable(total_q) && $stable(err_q), "total moved during stall")
	`MBSE_ASSERT_NOW(a_skip_zero, out_v_q && !counted_q, err_q == '0, "skipped block carries error")
	`MBSE_ASSERT_NEXT(a_total_mono, en && v_s3 && !clr_s3, total_q >= $past(total_q), "total decreased without clear")

endmodule

/* src/masked_block_squared_error_core.sv */
// ----------------------------------------------------------------------------
// masked_block_squared_error_core
// Masked per-block squared error against a coarse observation, with a
// saturating running total.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                              tuser                   tlast
//  s_axis    in   pred[23:0] obs[47:24]              open,grid_last,start    block_last
//  m_axis    out  block_error[63:0] total[127:64]    block_counted           run_done
//  cfg       in   cells_per_block (cfg_we/cfg_wdata, no read-back)
//
//  One cell is taken per cycle; the front end only stalls when the four-entry
//  block record queue is full.
//  A block's result passes the queue write at accept, then the product,
//  difference, square and total/output registers before it is valid.
//  The back end advances one block per cycle while m_axis is not stalled.
//  Reset clears the block accumulator, the total and sets cells_per_block to 1.
// ----------------------------------------------------------------------------
module masked_block_squared_error_core #(
	parameter int MAX_BLOCK_CELLS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	// configuration
	input  logic          cfg_we,
	input  logic [8:0]    cfg_wdata,       // cells_per_block
	// cell request
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [47:0]   s_axis_tdata,    // predicted_density, observed_density
	input  logic [2:0]    s_axis_tuser,    // cell_open, grid_last, start_run
	input  logic          s_axis_tlast,    // block_last
	// result request
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [127:0]  m_axis_tdata,    // block_error, running_total
	output logic          m_axis_tuser,    // block_counted
	output logic          m_axis_tlast     // run_done
);
	import mbse_pkg::*;

	blk_rec_t  wr_rec;
	blk_rec_t  rd_rec;
	logic      rec_push;
	logic      rec_full;
	logic      rec_pop;
	logic      rec_valid;

	// Cell intake and block accumulation
	mbse_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.pred       (s_axis_tdata[DENS_W-1:0]),
		.cell_open  (s_axis_tuser[0]),
		.obs        (s_axis_tdata[2*DENS_W-1:DENS_W]),
		.block_last (s_axis_tlast),
		.grid_last  (s_axis_tuser[1]),
		.start_run  (s_axis_tuser[2]),
		.rec_push   (rec_push),
		.rec        (wr_rec),
		.rec_full   (rec_full)
	);

	// Block record queue
	mbse_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (rec_push),
		.wr_data   (wr_rec),
		.full      (rec_full),
		.pop       (rec_pop),
		.rd_data   (rd_rec),
		.not_empty (rec_valid)
	);

	// Error computation and total
	mbse_back #(
		.MAX_BLOCK_CELLS (MAX_BLOCK_CELLS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.rec_valid     (rec_valid),
		.rec           (rd_rec),
		.rec_pop       (rec_pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.block_error   (m_axis_tdata[ERR_W-1:0]),
		.running_total (m_axis_tdata[2*ERR_W-1:ERR_W]),
		.block_counted (m_axis_tuser),
		.run_done      (m_axis_tlast)
	);

endmodule
